FILE: src/gef_pkg.sv
// shared types and constants of the gradient edge filter
package gef_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COL_OUT_W  = 11;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned WIDTH_W    = 12;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned WIN_TAPS   = 9;

  // floor(x / 3) for x <= 765 as (x * 683) >> 11
  localparam int unsigned DIV3_MUL   = 683;
  localparam int unsigned DIV3_SHIFT = 11;
  localparam int unsigned PROD_W     = 20;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
  localparam int unsigned         MIN_DIM    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE  = 2'd2;

  localparam logic MODE_SOBEL   = 1'b0;
  localparam logic MODE_PREWITT = 1'b1;

  localparam logic [PIX_W-1:0] SAT_MAX = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] center_col;
    logic [ROW_W-1:0]     center_row;
    logic [PIX_W-1:0]     grad_x_mag;
    logic [PIX_W-1:0]     grad_y_mag;
    logic                 frame_last;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  // tap k = row * 3 + col, row 0 is the oldest line
  typedef logic [WIN_TAPS-1:0][PIX_W-1:0] win_t;

endpackage

FILE: src/gef_chan_if.sv
// valid/ready channel carrying one payload per transfer
interface gef_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/gef_line_store.sv
// two line stores with registered read and one write port each
module gef_line_store #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [gef_pkg::PIX_W-1:0]  wr_upper_i,
  input  logic [gef_pkg::PIX_W-1:0]  wr_middle_i,
  output logic [gef_pkg::PIX_W-1:0]  rd_upper_o,
  output logic [gef_pkg::PIX_W-1:0]  rd_middle_o
);

  logic [gef_pkg::PIX_W-1:0] upper_mem  [DEPTH];
  logic [gef_pkg::PIX_W-1:0] middle_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= wr_upper_i;
      middle_mem[wr_addr_i] <= wr_middle_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_upper_o  <= upper_mem[rd_addr_i];
      rd_middle_o <= middle_mem[rd_addr_i];
    end
  end

endmodule

FILE: src/gef_kernel.sv
// sobel / prewitt gradient magnitudes of one 3x3 window, saturated
module gef_kernel (
  input  gef_pkg::win_t              win_i,
  input  logic                       mode_i,
  output logic [gef_pkg::PIX_W-1:0]  grad_x_mag_o,
  output logic [gef_pkg::PIX_W-1:0]  grad_y_mag_o
);

  function automatic logic [gef_pkg::PIX_W-1:0] grad_mag(
    input logic [gef_pkg::PIX_W-1:0] a0,
    input logic [gef_pkg::PIX_W-1:0] a1,
    input logic [gef_pkg::PIX_W-1:0] a2,
    input logic [gef_pkg::PIX_W-1:0] b0,
    input logic [gef_pkg::PIX_W-1:0] b1,
    input logic [gef_pkg::PIX_W-1:0] b2,
    input logic                      sobel
  );
    logic [9:0]  pos;
    logic [9:0]  neg;
    logic [10:0] diff;
    logic [10:0] mag;
    // center taps carry weight two in sobel mode
    pos  = 10'(a0) + (sobel ? {1'b0, a1, 1'b0} : 10'(a1)) + 10'(a2);
    neg  = 10'(b0) + (sobel ? {1'b0, b1, 1'b0} : 10'(b1)) + 10'(b2);
    diff = {1'b0, pos} - {1'b0, neg};
    mag  = diff[10] ? (~diff + 11'd1) : diff;
    return (mag > 11'(gef_pkg::SAT_MAX)) ? gef_pkg::SAT_MAX : mag[gef_pkg::PIX_W-1:0];
  endfunction

  logic sobel;

  assign sobel = (mode_i == gef_pkg::MODE_SOBEL);

  assign grad_x_mag_o = grad_mag(win_i[2], win_i[5], win_i[8],
                                 win_i[0], win_i[3], win_i[6], sobel);
  assign grad_y_mag_o = grad_mag(win_i[6], win_i[7], win_i[8],
                                 win_i[0], win_i[1], win_i[2], sobel);

endmodule

FILE: src/gradient_edge_filter_3x3.sv
// gradient_edge_filter_3x3 top level: gray conversion, line stores, window, gradients
// Takes one RGB pixel per clock in raster order and keeps that rate while results are taken:
// each pixel makes one read of both line stores at its column when it is accepted and one
// write back at the same column when it leaves the first stage, and consecutive pixels
// never share a column, so the single read and single write port of each store keep up
// without interlock. A result passes from the first stage through the second stage into
// the output register; a result held at the output backs the pipeline up to the pixel
// input. Only interior window centers give a result; border pixels pass through silently.
// Writing image_width or image_height restarts the frame at column 0, row 0; kernel_mode
// (0 sobel, 1 prewitt) applies at once. Widths below 3 act as 3 and above MAX_WIDTH as
// MAX_WIDTH; heights below 3 act as 3. The user must write configuration only while the
// pipeline is empty; the block does not enforce it. No clearing pass is needed.
module gradient_edge_filter_3x3 #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gef_chan_if.sink    pix_i,
  gef_chan_if.source  res_o,
  gef_chan_if.sink    cfg_i
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (WW > gef_pkg::WIDTH_W) ? WW : gef_pkg::WIDTH_W;
  localparam int unsigned XW   = (CW > gef_pkg::COL_OUT_W) ? CW : gef_pkg::COL_OUT_W;
  localparam int unsigned RW   = gef_pkg::ROW_W;

  // configuration
  logic [gef_pkg::WIDTH_W-1:0]  width_q;
  logic [gef_pkg::HEIGHT_W-1:0] height_q;
  logic                         mode_q;
  logic                         cfg_fire;
  logic                         cfg_restart;
  logic [CMPW-1:0]              width_ext;
  logic [WW-1:0]                eff_width;
  logic [RW-1:0]                eff_height;

  // raster position of the next pixel
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] col_inc;
  logic [RW:0]   row_inc;
  logic          col_wrap;
  logic          row_wrap;

  // accept stage
  logic                        in_fire;
  logic [gef_pkg::SUM_W-1:0]   pix_sum;
  logic [gef_pkg::PROD_W-1:0]  gray_prod;
  logic [gef_pkg::PIX_W-1:0]   gray;
  logic                        emit;
  logic                        last;

  // stage 1: line store data arrives
  logic                       s1_valid_q;
  logic [CW-1:0]              s1_col_q;
  logic [RW-1:0]              s1_row_q;
  logic [gef_pkg::PIX_W-1:0]  s1_gray_q;
  logic                       s1_emit_q;
  logic                       s1_last_q;
  logic                       s1_adv;
  logic                       s1_free;
  logic [gef_pkg::PIX_W-1:0]  ls_upper;
  logic [gef_pkg::PIX_W-1:0]  ls_middle;

  // stage 2: window complete, gradients
  logic                       s2_valid_q;
  logic [CW-1:0]              s2_col_q;
  logic [RW-1:0]              s2_row_q;
  logic                       s2_emit_q;
  logic                       s2_last_q;
  logic                       s2_adv;
  logic                       s2_free;
  gef_pkg::win_t              window_q;
  logic [gef_pkg::PIX_W-1:0]  grad_x;
  logic [gef_pkg::PIX_W-1:0]  grad_y;
  logic [XW-1:0]              center_col;

  // output register
  logic                       out_valid_q;
  gef_pkg::res_t              out_q;
  logic                       out_free;
  logic                       out_load;

  // ---------------------------------------------------------------- configuration
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign cfg_restart = cfg_fire &&
                       ((cfg_i.data.reg_idx == gef_pkg::REG_IMAGE_WIDTH) ||
                        (cfg_i.data.reg_idx == gef_pkg::REG_IMAGE_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gef_pkg::WIDTH_RST;
      height_q <= gef_pkg::HEIGHT_RST;
      mode_q   <= gef_pkg::MODE_SOBEL;
    end else if (cfg_fire) begin
      case (cfg_i.data.reg_idx)
        gef_pkg::REG_IMAGE_WIDTH: begin
          width_q <= cfg_i.data.wdata[gef_pkg::WIDTH_W-1:0];
        end
        gef_pkg::REG_IMAGE_HEIGHT: begin
          height_q <= cfg_i.data.wdata[gef_pkg::HEIGHT_W-1:0];
        end
        gef_pkg::REG_KERNEL_MODE: begin
          mode_q <= cfg_i.data.wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign width_ext  = CMPW'(width_q);
  assign eff_width  = (width_ext < CMPW'(gef_pkg::MIN_DIM)) ? WW'(gef_pkg::MIN_DIM) :
                      (width_ext > CMPW'(MAX_WIDTH))       ? WW'(MAX_WIDTH) :
                                                             WW'(width_ext);
  assign eff_height = (height_q < RW'(gef_pkg::MIN_DIM)) ? RW'(gef_pkg::MIN_DIM) : height_q;

  // ---------------------------------------------------------------- handshake chain
  assign out_free    = !out_valid_q || res_o.ready;
  assign s2_adv      = s2_valid_q && (!s2_emit_q || out_free);
  assign s2_free     = !s2_valid_q || s2_adv;
  assign s1_adv      = s1_valid_q && s2_free;
  assign s1_free     = !s1_valid_q || s1_adv;
  assign pix_i.ready = s1_free;
  assign in_fire     = pix_i.valid && s1_free;
  assign out_load    = s2_adv && s2_emit_q;

  // ---------------------------------------------------------------- accept stage
  assign pix_sum   = gef_pkg::SUM_W'(pix_i.data.red) + gef_pkg::SUM_W'(pix_i.data.green) +
                     gef_pkg::SUM_W'(pix_i.data.blue);
  assign gray_prod = gef_pkg::PROD_W'(pix_sum) * gef_pkg::PROD_W'(gef_pkg::DIV3_MUL);
  assign gray      = gray_prod[gef_pkg::DIV3_SHIFT +: gef_pkg::PIX_W];

  assign col_inc  = WW'(col_q) + WW'(1);
  assign row_inc  = {1'b0, row_q} + 17'd1;
  assign col_wrap = (col_inc >= eff_width);
  assign row_wrap = (row_inc >= {1'b0, eff_height});
  assign emit     = (col_q >= CW'(2)) && (row_q >= RW'(2));
  assign last     = col_wrap && row_wrap;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_inc[RW-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (s1_free) begin
        s1_valid_q <= in_fire;
      end
      if (s2_free) begin
        s2_valid_q <= s1_adv;
      end
      if (out_free) begin
        out_valid_q <= out_load;
      end
      // shift the window left, new column from the line stores and the new pixel
      if (s1_adv) begin
        for (int k = 0; k < 3; k++) begin
          window_q[k*3]   <= window_q[k*3+1];
          window_q[k*3+1] <= window_q[k*3+2];
        end
        window_q[2] <= ls_upper;
        window_q[5] <= ls_middle;
        window_q[8] <= s1_gray_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_gray_q <= gray;
      s1_emit_q <= emit;
      s1_last_q <= last;
    end
    if (s1_adv) begin
      s2_col_q  <= s1_col_q;
      s2_row_q  <= s1_row_q;
      s2_emit_q <= s1_emit_q;
      s2_last_q <= s1_last_q;
    end
    if (out_load) begin
      out_q.center_col <= center_col[gef_pkg::COL_OUT_W-1:0];
      out_q.center_row <= s2_row_q - RW'(1);
      out_q.grad_x_mag <= grad_x;
      out_q.grad_y_mag <= grad_y;
      out_q.frame_last <= s2_last_q;
    end
  end

  // ---------------------------------------------------------------- line stores
  // read at accept, write back as the pixel leaves stage 1: upper takes the old middle row
  gef_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk_i       (clk_i),
    .rd_en_i     (in_fire),
    .rd_addr_i   (col_q),
    .wr_en_i     (s1_adv),
    .wr_addr_i   (s1_col_q),
    .wr_upper_i  (ls_middle),
    .wr_middle_i (s1_gray_q),
    .rd_upper_o  (ls_upper),
    .rd_middle_o (ls_middle)
  );

  // ---------------------------------------------------------------- gradients
  gef_kernel u_kernel (
    .win_i        (window_q),
    .mode_i       (mode_q),
    .grad_x_mag_o (grad_x),
    .grad_y_mag_o (grad_y)
  );

  assign center_col = XW'(s2_col_q) - XW'(1);

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // ---------------------------------------------------------------- assertions
  a_no_same_col_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && in_fire) |-> (s1_col_q != col_q))
    else $error("line store read and write hit the same column");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WW'(col_q) < eff_width) && (row_q < eff_height))
    else $error("raster position outside the frame");

  a_emit_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_emit_q) |-> ((s2_col_q >= CW'(2)) && (s2_row_q >= RW'(2))))
    else $error("result from a border center");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_last) |-> (out_q.center_row == eff_height - RW'(2)))
    else $error("frame end flagged away from the last interior row");

  a_window_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_adv) |=> $stable(window_q))
    else $error("window changed under a stalled result");

endmodule
